FILE: sv/synaptic_delay_accumulator_defines.svh
// Assertion macros used by the checker.
`ifndef SYNAPTIC_DELAY_ACCUMULATOR_DEFINES_SVH
`define SYNAPTIC_DELAY_ACCUMULATOR_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a consequence in the next.
`define SDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/sda_pkg.sv
`timescale 1ns / 1ps

package sda_pkg;

	// Sizing
	localparam int NUM_TARGETS = 64;
	localparam int MAX_DELAY   = 15;
	localparam int TGT_W       = 6;
	localparam int SLOT_W      = 4;
	localparam int SUM_W       = 32;
	localparam int ADDR_W      = TGT_W + SLOT_W;
	localparam int RAM_DEPTH   = 2 ** ADDR_W;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Item kinds
	localparam logic MODE_DEPOSIT = 1'b0;
	localparam logic MODE_TICK    = 1'b1;

	// Register reset value
	localparam logic [SLOT_W-1:0] MAX_DELAY_RESET = 4'd15;

	// Classified command passed from front to back
	typedef struct packed {
		logic                     tick;
		logic [TGT_W-1:0]         tgt;
		logic [SLOT_W-1:0]        slot;
		logic signed [SUM_W-1:0]  current;
	} cmd_t;

	// Queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DEP_WR,
		ST_TICK_RD,
		ST_TICK_WR
	} st_t;

endpackage

FILE: sv/sda_ram.sv
`timescale 1ns / 1ps

module sda_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/sda_queue.sv
`timescale 1ns / 1ps

module sda_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sda_pkg::cmd_t    push_data,
	input  logic             pop,
	output sda_pkg::cmd_t    head,
	output sda_pkg::q_stat_t stat
);

	sda_pkg::cmd_t                   entry_q [sda_pkg::QUEUE_DEPTH];
	logic [sda_pkg::QPTR_W-1:0]      wr_q;
	logic [sda_pkg::QPTR_W-1:0]      rd_q;
	logic [sda_pkg::QCNT_W-1:0]      cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign stat.full  = (cnt_q == sda_pkg::QCNT_W'(sda_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entry_q[rd_q];

	// Store an incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == sda_pkg::QPTR_W'(sda_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == sda_pkg::QPTR_W'(sda_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: sv/sda_front.sv
`timescale 1ns / 1ps

module sda_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic [sda_pkg::TGT_W-1:0]        target_neuron,
	input  logic [sda_pkg::SLOT_W-1:0]       delay,
	input  logic signed [sda_pkg::SUM_W-1:0] current,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sda_pkg::SLOT_W-1:0]       cfg_data,
	input  logic                             clearing,
	input  sda_pkg::q_stat_t                 q_stat,
	output logic                             push,
	output sda_pkg::cmd_t                    push_data
);

	logic [sda_pkg::SLOT_W-1:0] mdu_q;
	logic [sda_pkg::SLOT_W-1:0] ptr_q;
	logic                       reduce_q;
	logic [sda_pkg::SLOT_W-1:0] mdu;
	logic [sda_pkg::SLOT_W-1:0] d_cl;
	logic [sda_pkg::SLOT_W:0]   slot_sum;
	logic [sda_pkg::SLOT_W:0]   slot_wrap;
	logic [sda_pkg::SLOT_W-1:0] dep_slot;
	logic                       tgt_ok;
	logic                       accept;
	logic                       is_tick;

	// Clamp the ring size register to the built depth
	assign mdu = (mdu_q > sda_pkg::SLOT_W'(sda_pkg::MAX_DELAY)) ?
		sda_pkg::SLOT_W'(sda_pkg::MAX_DELAY) : mdu_q;

	// Hold input while the pointer is being reduced, the store cleared or the queue full
	assign in_ready  = !reduce_q && !clearing && !q_stat.full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign is_tick   = (mode == sda_pkg::MODE_TICK);

	// Target slot of a deposit: clamp delay, add to pointer, wrap once
	always_comb begin
		d_cl      = (delay > mdu) ? mdu : delay;
		slot_sum  = {1'b0, ptr_q} + {1'b0, d_cl};
		slot_wrap = slot_sum - ({1'b0, mdu} + (sda_pkg::SLOT_W + 1)'(1));
		dep_slot  = (slot_sum > {1'b0, mdu}) ? slot_wrap[sda_pkg::SLOT_W-1:0] :
			slot_sum[sda_pkg::SLOT_W-1:0];
		tgt_ok    = ({1'b0, target_neuron} < (sda_pkg::TGT_W + 1)'(sda_pkg::NUM_TARGETS));
	end

	// Classify the beat; drop deposits to absent targets
	always_comb begin
		push              = accept && (is_tick || tgt_ok);
		push_data.tick    = is_tick;
		push_data.tgt     = target_neuron;
		push_data.slot    = is_tick ? ptr_q : dep_slot;
		push_data.current = current;
	end

	// Ring register, slot pointer and pointer reduction after a resize
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mdu_q    <= sda_pkg::MAX_DELAY_RESET;
			ptr_q    <= '0;
			reduce_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mdu_q    <= cfg_data;
				reduce_q <= 1'b1;
			end else if (reduce_q && !(ptr_q > mdu)) begin
				reduce_q <= 1'b0;
			end
			if (accept && is_tick) begin
				ptr_q <= (ptr_q == mdu) ? '0 : ptr_q + 1'b1;
			end else if (reduce_q && (ptr_q > mdu)) begin
				ptr_q <= ptr_q - (mdu + 1'b1);
			end
		end
	end

endmodule

FILE: sv/sda_back.sv
`timescale 1ns / 1ps

module sda_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sda_pkg::q_stat_t                  q_stat,
	input  sda_pkg::cmd_t                     head,
	output logic                              pop,
	output logic                              clearing,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sda_pkg::TGT_W-1:0]         target_index,
	output logic signed [sda_pkg::SUM_W-1:0]  accumulated_input,
	output logic                              last
);

	localparam logic [sda_pkg::TGT_W-1:0] LAST_TGT =
		sda_pkg::TGT_W'(sda_pkg::NUM_TARGETS - 1);
	localparam logic [sda_pkg::ADDR_W-1:0] LAST_ADDR =
		sda_pkg::ADDR_W'(sda_pkg::RAM_DEPTH - 1);
	localparam logic signed [sda_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(sda_pkg::SUM_W-1){1'b1}}};
	localparam logic signed [sda_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(sda_pkg::SUM_W-1){1'b0}}};

	sda_pkg::st_t                    state_q;
	sda_pkg::st_t                    state_d;
	logic [sda_pkg::ADDR_W-1:0]      clr_q;
	sda_pkg::cmd_t                   cmd_q;
	logic [sda_pkg::TGT_W-1:0]       t_q;
	logic                            out_valid_q;
	logic [sda_pkg::TGT_W-1:0]       out_tgt_q;
	logic [sda_pkg::SUM_W-1:0]       out_sum_q;
	logic                            out_last_q;
	logic                            out_free;
	logic                            load;
	logic                            we;
	logic [sda_pkg::ADDR_W-1:0]      waddr;
	logic [sda_pkg::SUM_W-1:0]       wdata;
	logic                            re;
	logic [sda_pkg::ADDR_W-1:0]      raddr;
	logic [sda_pkg::SUM_W-1:0]       rdata;
	logic [sda_pkg::SUM_W:0]         sum_wide;
	logic [sda_pkg::SUM_W-1:0]       sum_sat;

	assign out_free          = !out_valid_q || out_ready;
	assign clearing          = (state_q == sda_pkg::ST_CLEAR);
	assign out_valid         = out_valid_q;
	assign target_index      = out_tgt_q;
	assign accumulated_input = out_sum_q;
	assign last              = out_last_q;

	// Saturating add of the stored sum and the deposit
	always_comb begin
		sum_wide = {rdata[sda_pkg::SUM_W-1], rdata} +
			{cmd_q.current[sda_pkg::SUM_W-1], cmd_q.current};
		if (sum_wide[sda_pkg::SUM_W] != sum_wide[sda_pkg::SUM_W-1]) begin
			sum_sat = sum_wide[sda_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_wide[sda_pkg::SUM_W-1:0];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sda_pkg::ST_CLEAR: begin
				if (clr_q == LAST_ADDR) state_d = sda_pkg::ST_IDLE;
			end
			sda_pkg::ST_IDLE: begin
				if (!q_stat.empty) begin
					state_d = head.tick ? sda_pkg::ST_TICK_WR : sda_pkg::ST_DEP_WR;
				end
			end
			sda_pkg::ST_DEP_WR:  state_d = sda_pkg::ST_IDLE;
			sda_pkg::ST_TICK_RD: state_d = sda_pkg::ST_TICK_WR;
			sda_pkg::ST_TICK_WR: begin
				if (out_free) begin
					state_d = (t_q == LAST_TGT) ? sda_pkg::ST_IDLE : sda_pkg::ST_TICK_RD;
				end
			end
			default: state_d = sda_pkg::ST_IDLE;
		endcase
	end

	// Memory and queue controls per state
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		re    = 1'b0;
		raddr = '0;
		pop   = 1'b0;
		load  = 1'b0;
		unique case (state_q)
			sda_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			sda_pkg::ST_IDLE: begin
				if (!q_stat.empty) begin
					pop   = 1'b1;
					re    = 1'b1;
					raddr = head.tick ? {sda_pkg::TGT_W'(0), head.slot} : {head.tgt, head.slot};
				end
			end
			sda_pkg::ST_DEP_WR: begin
				we    = 1'b1;
				waddr = {cmd_q.tgt, cmd_q.slot};
				wdata = sum_sat;
			end
			sda_pkg::ST_TICK_RD: begin
				re    = 1'b1;
				raddr = {t_q, cmd_q.slot};
			end
			sda_pkg::ST_TICK_WR: begin
				if (out_free) begin
					load  = 1'b1;
					we    = 1'b1;
					waddr = {t_q, cmd_q.slot};
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Sequencer state, sweep counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sda_pkg::ST_CLEAR;
			clr_q       <= '0;
			t_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + 1'b1;
			if (pop) begin
				t_q <= '0;
			end else if (load && (t_q != LAST_TGT)) begin
				t_q <= t_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the command and the output beat
	always_ff @(posedge clk) begin
		if (pop) cmd_q <= head;
		if (load) begin
			out_tgt_q  <= t_q;
			out_sum_q  <= rdata;
			out_last_q <= (t_q == LAST_TGT);
		end
	end

	sda_ram #(
		.WIDTH(sda_pkg::SUM_W),
		.DEPTH(sda_pkg::RAM_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

endmodule

FILE: sv/synaptic_delay_accumulator.sv
`timescale 1ns / 1ps
// In the back end a deposit is a memory read, then a saturating write-back.
// A tick emits 64 beats, each a read, then a write-zero and output load that waits while the output is stalled.
// The first output beat of a tick passes through the queue, the slot read and the output register.
// Reset is asynchronous; afterwards a pass zeroes all 1024 slot memory entries, one
// entry per cycle, with input held off; the configuration port is always open.
module synaptic_delay_accumulator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic [sda_pkg::TGT_W-1:0]         target_neuron,
	input  logic [sda_pkg::SLOT_W-1:0]        delay,
	input  logic signed [sda_pkg::SUM_W-1:0]  current,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sda_pkg::TGT_W-1:0]         target_index,
	output logic signed [sda_pkg::SUM_W-1:0]  accumulated_input,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sda_pkg::SLOT_W-1:0]        cfg_data
);

	sda_pkg::cmd_t    push_data;
	sda_pkg::cmd_t    head;
	sda_pkg::q_stat_t q_stat;
	logic             push;
	logic             pop;
	logic             clearing;

	sda_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.target_neuron(target_neuron),
		.delay        (delay),
		.current      (current),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.clearing     (clearing),
		.q_stat       (q_stat),
		.push         (push),
		.push_data    (push_data)
	);

	sda_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	sda_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_stat           (q_stat),
		.head             (head),
		.pop              (pop),
		.clearing         (clearing),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.target_index     (target_index),
		.accumulated_input(accumulated_input),
		.last             (last)
	);

endmodule

FILE: sv/sda_checker.sv
`timescale 1ns / 1ps
`include "synaptic_delay_accumulator_defines.svh"

module sda_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [sda_pkg::TGT_W-1:0]         target_index,
	input logic signed [sda_pkg::SUM_W-1:0]  accumulated_input,
	input logic                              last
);

	localparam logic [sda_pkg::TGT_W-1:0] LAST_TGT =
		sda_pkg::TGT_W'(sda_pkg::NUM_TARGETS - 1);

	// A stalled output beat holds
	`SDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(target_index) && $stable(accumulated_input) && $stable(last), "stalled output beat changed")

	// The last flag marks exactly the final target
	`SDA_ASSERT(a_last_flag, !out_valid || (last == (target_index == LAST_TGT)), "last flag does not match target index")

	// Readout walks targets in order
	`SDA_ASSERT_NEXT(a_index_step, out_valid && out_ready && !last, !out_valid || (target_index == sda_pkg::TGT_W'($past(target_index) + 1'b1)), "readout skipped a target")

	// A beat right behind the final target starts a new readout at target zero
	`SDA_ASSERT_NEXT(a_end_wrap, out_valid && out_ready && last, !out_valid || (target_index == '0), "readout did not restart at target zero")

endmodule

bind synaptic_delay_accumulator sda_checker u_chk (.*);
